/* hw/rtl/dart_pkg.sv */
// Shared types, codes and a helper function for the divider and reloading timer.
`default_nettype none

package dart_pkg;

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	// Register selects.
	typedef enum logic [1:0] {
		SEL_DIVIDER = 2'd0,
		SEL_COUNTER = 2'd1,
		SEL_MODULO  = 2'd2,
		SEL_CONTROL = 2'd3
	} sel_t;

	// Widths of the internal state.
	localparam int unsigned CYCLE_W     = 14;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned PERIOD_W    = 9;
	localparam int unsigned DIV_LSB     = 6;

	// Prescaler periods selected by control bits 2..0.
	localparam logic [PERIOD_W-1:0] PERIOD_OFF = 9'd0;
	localparam logic [PERIOD_W-1:0] PERIOD_M4  = 9'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_M5  = 9'd4;
	localparam logic [PERIOD_W-1:0] PERIOD_M6  = 9'd16;
	localparam logic [PERIOD_W-1:0] PERIOD_M7  = 9'd64;

	// Result of one request.
	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              timer_irq;
		logic              bad_write;
	} result_t;

	// Prescaler period for a control byte; zero means the timer is stopped.
	function automatic logic [PERIOD_W-1:0] period_of(input logic [BYTE_W-1:0] control);
		logic [PERIOD_W-1:0] p;
		begin
			case (control[2:0])
				3'd4:    p = PERIOD_M4;
				3'd5:    p = PERIOD_M5;
				3'd6:    p = PERIOD_M6;
				3'd7:    p = PERIOD_M7;
				default: p = PERIOD_OFF;
			endcase
			return p;
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/dart_core.sv */
// Timer state registers and the combinational update for one request.
`default_nettype none

module dart_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [1:0]                   kind,
	input  wire logic [1:0]                   reg_sel,
	input  wire logic [dart_pkg::BYTE_W-1:0]  write_data,
	output dart_pkg::result_t                 result
);

	logic [dart_pkg::CYCLE_W-1:0]  cycle_q, cycle_d;
	logic [dart_pkg::BYTE_W-1:0]   presc_q, presc_d;
	logic [dart_pkg::BYTE_W-1:0]   counter_q, counter_d;
	logic [dart_pkg::BYTE_W-1:0]   modulo_q, modulo_d;
	logic [dart_pkg::BYTE_W-1:0]   control_q, control_d;

	logic [dart_pkg::PERIOD_W-1:0] run_period;
	logic [dart_pkg::PERIOD_W-1:0] new_period;
	logic [dart_pkg::PERIOD_W-1:0] presc_next;
	logic [dart_pkg::BYTE_W:0]     counter_inc;

	assign run_period  = dart_pkg::period_of(control_q);
	assign new_period  = dart_pkg::period_of(write_data);
	assign presc_next  = {1'b0, presc_q} + 9'd1;
	assign counter_inc = {1'b0, counter_q} + 9'd1;

	// Next state and result for the request in flight.
	always_comb begin
		cycle_d   = cycle_q;
		presc_d   = presc_q;
		counter_d = counter_q;
		modulo_d  = modulo_q;
		control_d = control_q;
		result    = '0;
		case (kind)
			dart_pkg::KIND_TICK: begin
				cycle_d = cycle_q + 14'd1;
				if (run_period != dart_pkg::PERIOD_OFF) begin
					if (presc_next >= run_period) begin
						presc_d = '0;
						// Overflow reloads from the modulo register.
						if (counter_inc[dart_pkg::BYTE_W]) begin
							counter_d        = modulo_q;
							result.timer_irq = 1'b1;
						end else begin
							counter_d = counter_inc[dart_pkg::BYTE_W-1:0];
						end
					end else begin
						presc_d = presc_next[dart_pkg::BYTE_W-1:0];
					end
				end
			end
			dart_pkg::KIND_READ: begin
				unique case (reg_sel)
					dart_pkg::SEL_DIVIDER: result.read_data =
						cycle_q[dart_pkg::CYCLE_W-1:dart_pkg::DIV_LSB];
					dart_pkg::SEL_COUNTER: result.read_data = counter_q;
					dart_pkg::SEL_MODULO:  result.read_data = modulo_q;
					default:               result.read_data = control_q;
				endcase
			end
			dart_pkg::KIND_WRITE: begin
				unique case (reg_sel)
					dart_pkg::SEL_DIVIDER: result.bad_write = 1'b1;
					dart_pkg::SEL_COUNTER: counter_d = write_data;
					dart_pkg::SEL_MODULO:  modulo_d  = write_data;
					default: begin
						control_d = write_data;
						// A shorter period clears the prescaler instead of bursting.
						if (new_period != dart_pkg::PERIOD_OFF &&
						    {1'b0, presc_q} >= new_period) begin
							presc_d = '0;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	// State registers advance only when a request completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q   <= '0;
			presc_q   <= '0;
			counter_q <= '0;
			modulo_q  <= '0;
			control_q <= '0;
		end else if (fire) begin
			cycle_q   <= cycle_d;
			presc_q   <= presc_d;
			counter_q <= counter_d;
			modulo_q  <= modulo_d;
			control_q <= control_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/divider_and_reloading_timer.sv */
// Top level of the divider and reloading timer with its request and result registers.
// Each request (a tick, a register read or a register write) is captured in an input
// register, handled against the timer state, and its result is held in an output
// register until taken; a new request is accepted every clock cycle while the input is
// not stalled. A result passes through the input register and the output register
// before it appears on the outputs. The block stalls its input only while a request
// waits in the input register, a result waits in the output register and the
// downstream side stalls.
`default_nettype none

module divider_and_reloading_timer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic [1:0]                   reg_sel,
	input  wire logic [dart_pkg::BYTE_W-1:0]  write_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [dart_pkg::BYTE_W-1:0]       read_data,
	output logic                              timer_irq,
	output logic                              bad_write
);

	logic                        valid_s1;
	logic [1:0]                  kind_s1;
	logic [1:0]                  reg_sel_s1;
	logic [dart_pkg::BYTE_W-1:0] write_data_s1;
	logic                        advance;
	logic                        fire;
	dart_pkg::result_t           result;
	dart_pkg::result_t           result_q;
	logic                        out_valid_q;

	// The request stage moves on whenever the output register is free or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1       <= kind;
			reg_sel_s1    <= reg_sel;
			write_data_s1 <= write_data;
		end
	end

	dart_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.kind       (kind_s1),
		.reg_sel    (reg_sel_s1),
		.write_data (write_data_s1),
		.result     (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = result_q.read_data;
	assign timer_irq = result_q.timer_irq;
	assign bad_write = result_q.bad_write;

	// An interrupt only comes from a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.timer_irq |-> kind_s1 == dart_pkg::KIND_TICK)
		else $error("timer interrupt raised by a request that is not a tick");

	// Only reads return data.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.read_data != '0 |-> kind_s1 == dart_pkg::KIND_READ)
		else $error("read data returned by a request that is not a read");

	// A stalled request stays in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(kind_s1) && $stable(reg_sel_s1))
		else $error("stalled request lost from the input register");

	// A result is never both an interrupt and a rejected write.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(timer_irq && bad_write))
		else $error("interrupt and rejected write in one result");

endmodule

`default_nettype wire
